/* src/multiset_window_matcher_defines.svh */
// ----------------------------------------------------------------------------
// multiset_window_matcher_defines
// Assertion macros used by the multiset window matcher.
// ----------------------------------------------------------------------------
`ifndef MULTISET_WINDOW_MATCHER_DEFINES_SVH
`define MULTISET_WINDOW_MATCHER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MWM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mwm_pkg.sv */
// ----------------------------------------------------------------------------
// mwm_pkg
// Sizes, action codes and pipeline beat type of the multiset window matcher.
// ----------------------------------------------------------------------------
package mwm_pkg;

  // window and position sizing
  localparam int unsigned MAX_WINDOW    = 256;
  localparam int unsigned POSITION_BITS = 32;

  // byte symbol space
  localparam int unsigned SYM_NUM = 256;
  localparam int unsigned SYM_W   = $clog2(SYM_NUM);

  // derived widths
  localparam int unsigned RING_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned LEN_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CNT_W   = LEN_W + 1;
  localparam int unsigned SCNT_W  = $clog2(SYM_NUM + 1);
  localparam int unsigned MATCH_W = 32;

  // result queue
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned OCC_W      = $clog2(OUTQ_DEPTH + 3);

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } action_e;

  // one decoded beat moving down the pipeline
  typedef struct packed {
    logic                     clr;
    logic                     pat;
    logic                     txt;
    logic                     leave;
    logic                     win;
    logic [SYM_W-1:0]         sym;
    logic [POSITION_BITS-1:0] start;
  } beat_t;

endpackage

/* src/multiset_window_matcher.sv */
// ----------------------------------------------------------------------------
// multiset_window_matcher
// Reports every text window whose bytes are a permutation of the loaded pattern.
// ----------------------------------------------------------------------------
// Input channel: valid_i / stall_o carry action_i and byte_value_i. A clear
// beat starts a new pattern, pattern beats load the pattern multiset, text
// beats slide the window over the text.
// Output channel: valid_o / stall_i carry match_position_o, the text index
// where a matching window starts; a text beat gives at most one result.
// Throughput: one beat per cycle while stall_o is low. A result reaches
// valid_o in order: the window ring is read as the beat is taken, then the
// dual-read count tables are read, and then the count update and zero
// tracking load the result queue.
// A four-entry result queue is booked per beat in flight; stall_o rises when
// four beats are in the pipe or queued, so at most four results wait on a
// stalled receiver and no result is ever dropped.
// Reset empties the pipe and the queue and leaves an empty pattern; a
// clearing pass then zeroes the count tables, and stall_o stays high
// until it is done.
// ----------------------------------------------------------------------------
`include "multiset_window_matcher_defines.svh"

module multiset_window_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  byte_value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] match_position_o
);

  localparam int unsigned BANK_P = 0;  // pattern counts
  localparam int unsigned BANK_E = 1;  // bytes that entered the window
  localparam int unsigned BANK_L = 2;  // bytes that left the window
  localparam int unsigned BANKS  = 3;
  localparam int unsigned RSUM_W = mwm_pkg::LEN_W + 1;

  // --------------------------------------------------------------------------
  // front state, updated as beats are taken
  // --------------------------------------------------------------------------
  logic                               accept;
  mwm_pkg::action_e                   act;
  mwm_pkg::beat_t                     s0;
  logic                               s0_valid;
  logic [mwm_pkg::LEN_W-1:0]          len_q, len_d, fill_q, fill_d;
  logic [mwm_pkg::RING_AW-1:0]        head_q, head_d, ring_ra;
  logic [RSUM_W-1:0]                  ring_sum;
  logic                               started_q, started_d;
  logic [mwm_pkg::POSITION_BITS-1:0]  pos_q, pos_d;

  assign accept = valid_i && !stall_o;
  assign act    = mwm_pkg::action_e'(action_i);

  // decode the beat and advance the window bookkeeping
  always_comb begin
    s0        = '0;
    s0.sym    = byte_value_i;
    s0.start  = pos_q - mwm_pkg::POSITION_BITS'(len_q) + mwm_pkg::POSITION_BITS'(1);
    len_d     = len_q;
    fill_d    = fill_q;
    head_d    = head_q;
    started_d = started_q;
    pos_d     = pos_q;
    case (act)
      mwm_pkg::ACT_CLEAR: begin
        s0.clr    = 1'b1;
        len_d     = '0;
        fill_d    = '0;
        head_d    = '0;
        started_d = 1'b0;
        pos_d     = '0;
      end
      mwm_pkg::ACT_PATTERN: begin
        if (!started_q && (len_q < mwm_pkg::LEN_W'(mwm_pkg::MAX_WINDOW))) begin
          s0.pat = 1'b1;
          len_d  = len_q + mwm_pkg::LEN_W'(1);
        end
      end
      mwm_pkg::ACT_TEXT: begin
        s0.txt    = 1'b1;
        s0.win    = (len_q != '0);
        s0.leave  = (len_q != '0) && (fill_q >= len_q);
        head_d    = (head_q == mwm_pkg::RING_AW'(mwm_pkg::MAX_WINDOW - 1)) ?
                    '0 : head_q + mwm_pkg::RING_AW'(1);
        fill_d    = (fill_q < len_q) ? fill_q + mwm_pkg::LEN_W'(1) : fill_q;
        started_d = 1'b1;
        pos_d     = pos_q + mwm_pkg::POSITION_BITS'(1);
      end
      default: ;
    endcase
  end

  assign s0_valid = s0.clr || s0.pat || s0.txt;

  // ring slot of the byte leaving the window
  always_comb begin
    ring_sum = RSUM_W'(head_q) + RSUM_W'(mwm_pkg::MAX_WINDOW) - RSUM_W'(len_q);
    if (ring_sum >= RSUM_W'(mwm_pkg::MAX_WINDOW)) begin
      ring_ra = mwm_pkg::RING_AW'(ring_sum - RSUM_W'(mwm_pkg::MAX_WINDOW));
    end else begin
      ring_ra = mwm_pkg::RING_AW'(ring_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      fill_q    <= '0;
      head_q    <= '0;
      started_q <= 1'b0;
      pos_q     <= '0;
    end else if (accept) begin
      len_q     <= len_d;
      fill_q    <= fill_d;
      head_q    <= head_d;
      started_q <= started_d;
      pos_q     <= pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // recent text ring, read before write
  // --------------------------------------------------------------------------
  logic [mwm_pkg::SYM_W-1:0] ring_mem [mwm_pkg::MAX_WINDOW];
  logic [mwm_pkg::SYM_W-1:0] ring_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && s0.txt) begin
      ring_mem[head_q] <= byte_value_i;
    end
    if (accept) begin
      ring_rd_q <= ring_mem[ring_ra];
    end
  end

  // --------------------------------------------------------------------------
  // clearing pass: zero the count tables after reset
  // --------------------------------------------------------------------------
  logic                      init_busy_q;
  logic [mwm_pkg::SYM_W-1:0] init_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_busy_q <= 1'b1;
      init_addr_q <= '0;
    end else if (init_busy_q) begin
      init_addr_q <= init_addr_q + mwm_pkg::SYM_W'(1);
      if (init_addr_q == mwm_pkg::SYM_W'(mwm_pkg::SYM_NUM - 1)) begin
        init_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: count table reads at entering and leaving byte
  // --------------------------------------------------------------------------
  logic           s1_valid_q;
  mwm_pkg::beat_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && s0_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s0;
    end
  end

  logic [mwm_pkg::CNT_W-1:0] cmem [BANKS][mwm_pkg::SYM_NUM];
  logic [mwm_pkg::CNT_W-1:0] rd_e_q [BANKS];
  logic [mwm_pkg::CNT_W-1:0] rd_l_q [BANKS];
  logic                      wr_en [BANKS];
  logic [mwm_pkg::SYM_W-1:0] wr_addr [BANKS];
  logic [mwm_pkg::CNT_W-1:0] wr_data [BANKS];

  // three single-write, dual-read count tables
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < BANKS; b++) begin
      if (wr_en[b]) begin
        cmem[b][wr_addr[b]] <= wr_data[b];
      end
      if (s1_valid_q) begin
        rd_e_q[b] <= cmem[b][s1_q.sym];
        rd_l_q[b] <= cmem[b][ring_rd_q];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: count update, zero tracking, match detect
  // --------------------------------------------------------------------------
  logic                      s2_valid_q;
  mwm_pkg::beat_t            s2_q;
  logic [mwm_pkg::SYM_W-1:0] s2_leave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_q       <= s1_q;
      s2_leave_q <= ring_rd_q;
    end
  end

  logic                       fwd_we_q [BANKS];
  logic [mwm_pkg::SYM_W-1:0]  fwd_wa_q [BANKS];
  logic [mwm_pkg::CNT_W-1:0]  fwd_wd_q [BANKS];
  logic [mwm_pkg::CNT_W-1:0]  e_val [BANKS];
  logic [mwm_pkg::CNT_W-1:0]  l_val [BANKS];
  logic [mwm_pkg::CNT_W-1:0]  cnt_l, cnt_l1, cnt_e, cnt_e0, cnt_e1;
  logic                       mem_e, mem_l, leave_act, enter_act;
  logic [mwm_pkg::SCNT_W-1:0] z1, z2;
  logic [mwm_pkg::SYM_NUM-1:0] member_q, member_d;
  logic [mwm_pkg::SCNT_W-1:0] distinct_q, distinct_d, zeroed_q, zeroed_d;
  logic                       match;
  logic [mwm_pkg::POSITION_BITS+mwm_pkg::MATCH_W-1:0] start_ext;

  // pick up the write of the beat just ahead
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      e_val[b] = (fwd_we_q[b] && (fwd_wa_q[b] == s2_q.sym))   ? fwd_wd_q[b] : rd_e_q[b];
      l_val[b] = (fwd_we_q[b] && (fwd_wa_q[b] == s2_leave_q)) ? fwd_wd_q[b] : rd_l_q[b];
    end
  end

  // remaining count is pattern count plus bytes left minus bytes entered
  always_comb begin
    mem_e     = member_q[s2_q.sym];
    mem_l     = member_q[s2_leave_q];
    cnt_l     = l_val[BANK_P] + l_val[BANK_L] - l_val[BANK_E];
    cnt_e     = e_val[BANK_P] + e_val[BANK_L] - e_val[BANK_E];
    leave_act = s2_valid_q && s2_q.txt && s2_q.leave && mem_l;
    enter_act = s2_valid_q && s2_q.txt && mem_e;
    cnt_l1    = cnt_l + mwm_pkg::CNT_W'(1);

    // leaving byte goes back into the budget
    z1 = zeroed_q;
    if (leave_act) begin
      if ((cnt_l == '0) && (z1 != '0)) begin
        z1 = z1 - mwm_pkg::SCNT_W'(1);
      end
      if (cnt_l1 == '0) begin
        z1 = z1 + mwm_pkg::SCNT_W'(1);
      end
    end

    // entering byte is counted against it
    cnt_e0 = (leave_act && (s2_leave_q == s2_q.sym)) ? cnt_l1 : cnt_e;
    cnt_e1 = cnt_e0 - mwm_pkg::CNT_W'(1);
    z2 = z1;
    if (enter_act) begin
      if ((cnt_e0 == '0) && (z2 != '0)) begin
        z2 = z2 - mwm_pkg::SCNT_W'(1);
      end
      if (cnt_e1 == '0) begin
        z2 = z2 + mwm_pkg::SCNT_W'(1);
      end
    end
  end

  // table writes and membership
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      wr_en[b]   = 1'b0;
      wr_addr[b] = s2_q.sym;
      wr_data[b] = e_val[b] + mwm_pkg::CNT_W'(1);
    end
    wr_addr[BANK_L] = s2_leave_q;
    wr_data[BANK_L] = l_val[BANK_L] + mwm_pkg::CNT_W'(1);
    member_d   = member_q;
    distinct_d = distinct_q;
    zeroed_d   = zeroed_q;
    if (s2_valid_q) begin
      if (s2_q.clr) begin
        member_d   = '0;
        distinct_d = '0;
        zeroed_d   = '0;
      end
      if (s2_q.pat) begin
        wr_en[BANK_P] = 1'b1;
        if (!mem_e) begin
          // new symbol: seed so that the remaining count reads one
          wr_data[BANK_P]    = mwm_pkg::CNT_W'(1) + e_val[BANK_E] - e_val[BANK_L];
          member_d[s2_q.sym] = 1'b1;
          distinct_d         = distinct_q + mwm_pkg::SCNT_W'(1);
        end
      end
      if (s2_q.txt) begin
        wr_en[BANK_E] = 1'b1;
        wr_en[BANK_L] = s2_q.leave;
        zeroed_d      = z2;
      end
    end
    // clearing pass after reset
    if (init_busy_q) begin
      for (int b = 0; b < BANKS; b++) begin
        wr_en[b]   = 1'b1;
        wr_addr[b] = init_addr_q;
        wr_data[b] = '0;
      end
    end
  end

  assign match     = s2_valid_q && s2_q.txt && s2_q.win && (z2 == distinct_q);
  assign start_ext = {{mwm_pkg::MATCH_W{1'b0}}, s2_q.start};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q   <= '0;
      distinct_q <= '0;
      zeroed_q   <= '0;
      for (int b = 0; b < BANKS; b++) begin
        fwd_we_q[b] <= 1'b0;
      end
    end else begin
      member_q   <= member_d;
      distinct_q <= distinct_d;
      zeroed_q   <= zeroed_d;
      for (int b = 0; b < BANKS; b++) begin
        fwd_we_q[b] <= wr_en[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < BANKS; b++) begin
      fwd_wa_q[b] <= wr_addr[b];
      fwd_wd_q[b] <= wr_data[b];
    end
  end

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  logic [mwm_pkg::MATCH_W-1:0] q_mem [mwm_pkg::OUTQ_DEPTH];
  logic [mwm_pkg::OUTQ_AW-1:0] q_wr_q, q_rd_q;
  logic [mwm_pkg::OUTQ_CW-1:0] q_cnt_q;
  logic [mwm_pkg::OCC_W-1:0]   occ;
  logic                        pop;

  assign pop     = valid_o && !stall_i;
  assign occ     = mwm_pkg::OCC_W'(q_cnt_q) + mwm_pkg::OCC_W'(s1_valid_q)
                 + mwm_pkg::OCC_W'(s2_valid_q);
  assign stall_o = init_busy_q || (occ >= mwm_pkg::OCC_W'(mwm_pkg::OUTQ_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (match) begin
        q_wr_q <= q_wr_q + mwm_pkg::OUTQ_AW'(1);
      end
      if (pop) begin
        q_rd_q <= q_rd_q + mwm_pkg::OUTQ_AW'(1);
      end
      case ({match, pop})
        2'b10:   q_cnt_q <= q_cnt_q + mwm_pkg::OUTQ_CW'(1);
        2'b01:   q_cnt_q <= q_cnt_q - mwm_pkg::OUTQ_CW'(1);
        default: q_cnt_q <= q_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      q_mem[q_wr_q] <= start_ext[mwm_pkg::MATCH_W-1:0];
    end
  end

  assign valid_o          = (q_cnt_q != '0);
  assign match_position_o = q_mem[q_rd_q];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `MWM_ASSERT_NOW(a_occupancy, clk_i, rst_ni, 1'b1, occ <= mwm_pkg::OCC_W'(mwm_pkg::OUTQ_DEPTH), "result queue overbooked")
  `MWM_ASSERT_NOW(a_push_room, clk_i, rst_ni, match, (q_cnt_q != mwm_pkg::OUTQ_CW'(mwm_pkg::OUTQ_DEPTH)) || pop, "result pushed into full queue")
  `MWM_ASSERT_NOW(a_zeroed_bound, clk_i, rst_ni, 1'b1, zeroed_q <= distinct_q, "more zeroed symbols than pattern symbols")
  `MWM_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, s2_valid_q && s2_q.clr, (distinct_q == '0) && (member_q == '0), "clear left pattern state behind")

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multiset window matcher. A queue of beats
// of every action code is filled up front and fed through a valid/stall
// driver with random gaps. A local model of the pattern counts and the
// sliding window predicts every match start. A monitor compares each result
// beat against the oldest prediction while the receiver stalls at random,
// with one long hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] ACT_NONE = 2'd3;   // action code with no meaning
  localparam int unsigned STUCK_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] sym;
  } stim_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [1:0]  action_i = mwm_pkg::ACT_CLEAR;
  logic [7:0]  byte_value_i = 8'h00;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] match_position_o;

  multiset_window_matcher DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .action_i        (action_i),
    .byte_value_i    (byte_value_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .match_position_o(match_position_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // pending beats and predicted match starts
  stim_beat_t  beats_q[$];
  logic [31:0] match_starts_q[$];
  int unsigned stim_n = 0;
  int unsigned err_n = 0;
  int unsigned in_count = 0;
  int unsigned cyc = 0;
  logic        in_taken = 1'b0;
  logic        quiet;

  // window model state
  int                                sym_cnt[mwm_pkg::SYM_NUM];
  bit                                sym_member[mwm_pkg::SYM_NUM];
  int unsigned                       distinct_n, zeroed_n, win_len, win_fill, ring_head;
  logic [mwm_pkg::POSITION_BITS-1:0] text_pos;
  logic [7:0]                        ring[mwm_pkg::MAX_WINDOW];
  bit                                text_seen;

  // driver and receiver pacing
  int unsigned send_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  bit          pressure_done = 1'b0;

  assign quiet = (cyc[9:8] == 2'b11);

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s, expected %h, got %h", $time, what, want, got);
    err_n++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_window();
    for (int i = 0; i < mwm_pkg::SYM_NUM; i++) begin
      sym_cnt[i] = 0;
      sym_member[i] = 1'b0;
    end
    distinct_n = 0;
    zeroed_n = 0;
    win_len = 0;
    win_fill = 0;
    ring_head = 0;
    text_pos = '0;
    text_seen = 1'b0;
  endtask

  // move one member symbol's count and keep the zero tally
  task automatic bump_symbol(input logic [7:0] s, input int delta);
    if (!sym_member[s]) return;
    if (sym_cnt[s] == 0 && zeroed_n > 0) zeroed_n--;
    sym_cnt[s] = sym_cnt[s] + delta;
    if (sym_cnt[s] == 0) zeroed_n++;
  endtask

  // predict the effect of one accepted beat
  task automatic track_beat(input logic [1:0] act, input logic [7:0] s);
    logic [mwm_pkg::POSITION_BITS-1:0] start;
    case (act)
      mwm_pkg::ACT_CLEAR: clear_window();
      mwm_pkg::ACT_PATTERN: begin
        if (!text_seen && win_len < mwm_pkg::MAX_WINDOW) begin
          if (!sym_member[s]) begin
            sym_member[s] = 1'b1;
            sym_cnt[s] = 0;
            distinct_n++;
          end
          sym_cnt[s] = sym_cnt[s] + 1;
          win_len++;
        end
      end
      mwm_pkg::ACT_TEXT: begin
        text_seen = 1'b1;
        // byte leaving the window goes back into the counts
        if (win_len > 0 && win_fill >= win_len)
          bump_symbol(ring[mwm_pkg::RING_AW'((ring_head + mwm_pkg::MAX_WINDOW - win_len)
                                             % mwm_pkg::MAX_WINDOW)], 1);
        bump_symbol(s, -1);
        ring[mwm_pkg::RING_AW'(ring_head)] = s;
        ring_head = (ring_head + 1) % mwm_pkg::MAX_WINDOW;
        if (win_fill < win_len) win_fill++;
        if (win_len > 0 && zeroed_n == distinct_n) begin
          start = text_pos - mwm_pkg::POSITION_BITS'(win_len)
                + mwm_pkg::POSITION_BITS'(1);
          match_starts_q.push_back(start[31:0]);
        end
        text_pos = text_pos + mwm_pkg::POSITION_BITS'(1);
      end
      default: ;
    endcase
  endtask

  task automatic queue_beat(input logic [1:0] act, input logic [7:0] s);
    beats_q.push_back('{act: act, sym: s});
    if (act != ACT_NONE) stim_n++;
  endtask

  // one random run: usually a clear, then a pattern from a small palette, text mostly from it
  task automatic random_run();
    logic [7:0]  pal[4];
    int unsigned pat_len, txt_len, k, r;
    k = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) pal[i] = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 5) pat_len = 0;
    else if (r < 85) pat_len = $urandom_range(1, 6);
    else pat_len = $urandom_range(7, 40);
    txt_len = $urandom_range(10, 60);
    if ($urandom_range(0, 99) >= 8) queue_beat(mwm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
    for (int i = 0; i < pat_len; i++)
      queue_beat(mwm_pkg::ACT_PATTERN, pal[2'($urandom_range(0, k - 1))]);
    for (int i = 0; i < txt_len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) queue_beat(mwm_pkg::ACT_TEXT, pal[2'($urandom_range(0, k - 1))]);
      else if (r < 95) queue_beat(mwm_pkg::ACT_TEXT, 8'($urandom_range(0, 255)));
      else if (r < 98) queue_beat(ACT_NONE, 8'($urandom_range(0, 255)));
      else queue_beat(mwm_pkg::ACT_PATTERN, 8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus and end of run
  initial begin : stim
    logic [7:0] v;
    bit         long_done;
    long_done = 1'b0;
    clear_window();
    // directed: empty pattern, undefined action, byte extremes,
    // non-pattern byte, pattern after text, clear with a stray byte
    queue_beat(mwm_pkg::ACT_CLEAR, 8'h00);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h00);
    queue_beat(mwm_pkg::ACT_TEXT, 8'hFF);
    queue_beat(ACT_NONE, 8'hA5);
    queue_beat(mwm_pkg::ACT_CLEAR, 8'h00);
    queue_beat(mwm_pkg::ACT_PATTERN, 8'h00);
    queue_beat(mwm_pkg::ACT_PATTERN, 8'hFF);
    queue_beat(mwm_pkg::ACT_PATTERN, 8'h00);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h5A);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h00);
    queue_beat(mwm_pkg::ACT_TEXT, 8'hFF);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h00);
    queue_beat(mwm_pkg::ACT_TEXT, 8'hFF);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h00);
    queue_beat(mwm_pkg::ACT_PATTERN, 8'h41);
    queue_beat(ACT_NONE, 8'h00);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h00);
    queue_beat(mwm_pkg::ACT_CLEAR, 8'hFF);
    queue_beat(mwm_pkg::ACT_PATTERN, 8'h80);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h80);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h80);
    queue_beat(mwm_pkg::ACT_TEXT, 8'h7F);
    // random runs, with one overlong pattern that wraps the ring
    while (stim_n < 1800) begin
      if (!long_done && stim_n > 900) begin
        long_done = 1'b1;
        v = 8'($urandom_range(0, 255));
        queue_beat(mwm_pkg::ACT_CLEAR, 8'h00);
        for (int i = 0; i < mwm_pkg::MAX_WINDOW + 2; i++) queue_beat(mwm_pkg::ACT_PATTERN, v);
        for (int i = 0; i < mwm_pkg::MAX_WINDOW + 14; i++)
          queue_beat(mwm_pkg::ACT_TEXT,
                     ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : v);
      end else begin
        random_run();
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (beats_q.size() != 0 || valid_i || match_starts_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (err_n == 0 && match_starts_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // input driver
  always @(negedge clk_i) begin : drive_in
    stim_beat_t nxt;
    if (rst_ni && (!valid_i || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        valid_i <= 1'b0;
      end else if (beats_q.size() != 0) begin
        nxt = beats_q.pop_front();
        valid_i <= 1'b1;
        action_i <= nxt.act;
        byte_value_i <= nxt.sym;
        send_gap = quiet ? 0 : gap_len();
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off partway through
  always @(negedge clk_i) begin : drive_stall
    logic nxt;
    if (!rst_ni) begin
      nxt = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b1;
    end else if (!pressure_done && in_count >= 600) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
      nxt = 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      nxt = 1'b1;
    end else begin
      nxt = 1'b0;
      if (!quiet && $urandom_range(0, 3) == 0) rx_gap = gap_len();
    end
    stall_i <= nxt;
  end

  // monitor: check result beats, predict from input beats
  always @(posedge clk_i) begin : monitor
    logic [31:0] want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      cyc++;
      in_taken <= valid_i && !stall_o;
      if (valid_o && !stall_i) begin
        if (match_starts_q.size() == 0) begin
          report_mismatch("result with nothing expected", 32'h0, match_position_o);
        end else begin
          want = match_starts_q.pop_front();
          if (match_position_o !== want)
            report_mismatch("match_position", want, match_position_o);
        end
      end
      if (valid_i && !stall_o) begin
        track_beat(action_i, byte_value_i);
        in_count++;
      end
    end
  end

  // watchdog on cycles with no beat moving
  int unsigned stuck_cycles = 0;
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

endmodule
